// File: src/ddodo_pkg.sv
// ----------------------------------------------------------------------------
// ddodo_pkg
// Types, codes and constants shared by the odometry controller, datapath and
// top level.
// ----------------------------------------------------------------------------
package ddodo_pkg;

  typedef struct packed {
    logic signed [15:0] right_speed;
    logic signed [15:0] left_speed;
    logic               restart;
  } ddodo_in_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] heading;
  } ddodo_out_t;

  typedef enum logic [2:0] {
    CFG_WHEEL_RADIUS     = 3'd0,
    CFG_TRACK_RECIPROCAL = 3'd1,
    CFG_TIME_STEP        = 3'd2,
    CFG_START_X          = 3'd3,
    CFG_START_Y          = 3'd4,
    CFG_START_HEADING    = 3'd5
  } cfg_reg_t;

  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 24;

  // Reset values of the configuration and pose registers
  localparam logic [15:0]        WHEEL_RADIUS_RST  = 16'd7680;
  localparam logic [23:0]        TRACK_RECIP_RST   = 24'd74565;
  localparam logic [15:0]        TIME_STEP_RST     = 16'd2621;
  localparam logic signed [23:0] START_X_RST       = -24'sd217600;
  localparam logic signed [23:0] START_Y_RST       = -24'sd294400;
  localparam logic signed [15:0] START_HEADING_RST = 16'sd16384;

  // 2^32 / (2*pi) scaled for a Q16 angle in radians
  localparam logic signed [30:0] ANGLE_GAIN = 31'sd683565276;
  // CORDIC gain 0.607252935 in Q24
  localparam logic signed [26:0] CORDIC_K = 27'sd10188014;

  localparam int ATAN_DEPTH = 24;
  localparam int ATAN_IW    = 5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_SUM,
    ST_MUL_DIFF,
    ST_MUL_TRK,
    ST_MUL_DTW,
    ST_MUL_GAIN,
    ST_HEAD,
    ST_COR_INIT,
    ST_COR_STEP,
    ST_MUL_VC,
    ST_MUL_TDTX,
    ST_MUL_VS,
    ST_MUL_TDTY,
    ST_UPD_Y,
    ST_DONE
  } ctrl_state_t;

  // Operand pairs for the shared multiplier
  typedef enum logic [2:0] {
    MS_NONE,
    MS_SUM,
    MS_DIFF,
    MS_TRK,
    MS_DT_W,
    MS_GAIN,
    MS_VCOS,
    MS_VSIN
  } mul_sel_t;

  typedef struct packed {
    logic                 load_in;
    mul_sel_t             mul_sel;
    logic                 mul_tdt;
    logic                 cap_v8;
    logic                 upd_head;
    logic                 cor_init;
    logic                 cor_step;
    logic [ATAN_IW-1:0]   cor_idx;
    logic                 upd_x;
    logic                 upd_y;
    logic                 out_load;
  } dp_cmd_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_lut(input logic [ATAN_IW-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/ddodo_ctrl.sv
// ----------------------------------------------------------------------------
// ddodo_ctrl
// Sequencer for one odometry update: multiplier schedule, CORDIC rotations,
// pose updates and the result register handshake.
// ----------------------------------------------------------------------------
module ddodo_ctrl
  import ddodo_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_restart,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  localparam int STEPS = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;
  localparam logic [ATAN_IW-1:0] LAST_STEP = ATAN_IW'(STEPS - 1);

  ctrl_state_t        state_r, state_nxt;
  logic [ATAN_IW-1:0] cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    cmd.mul_sel   = MS_NONE;
    cmd.cor_idx   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = in_restart ? ST_DONE : ST_MUL_SUM;
        end
      end
      ST_MUL_SUM: begin
        cmd.mul_sel = MS_SUM;
        state_nxt   = ST_MUL_DIFF;
      end
      ST_MUL_DIFF: begin
        cmd.cap_v8  = 1'b1;
        cmd.mul_sel = MS_DIFF;
        state_nxt   = ST_MUL_TRK;
      end
      ST_MUL_TRK: begin
        cmd.mul_sel = MS_TRK;
        state_nxt   = ST_MUL_DTW;
      end
      ST_MUL_DTW: begin
        cmd.mul_sel = MS_DT_W;
        state_nxt   = ST_MUL_GAIN;
      end
      ST_MUL_GAIN: begin
        cmd.mul_sel = MS_GAIN;
        state_nxt   = ST_HEAD;
      end
      ST_HEAD: begin
        cmd.upd_head = 1'b1;
        state_nxt    = ST_COR_INIT;
      end
      ST_COR_INIT: begin
        cmd.cor_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_COR_STEP;
      end
      ST_COR_STEP: begin
        cmd.cor_step = 1'b1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_MUL_VC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MUL_VC: begin
        cmd.mul_sel = MS_VCOS;
        state_nxt   = ST_MUL_TDTX;
      end
      ST_MUL_TDTX: begin
        cmd.mul_tdt = 1'b1;
        state_nxt   = ST_MUL_VS;
      end
      ST_MUL_VS: begin
        cmd.upd_x   = 1'b1;
        cmd.mul_sel = MS_VSIN;
        state_nxt   = ST_MUL_TDTY;
      end
      ST_MUL_TDTY: begin
        cmd.mul_tdt = 1'b1;
        state_nxt   = ST_UPD_Y;
      end
      ST_UPD_Y: begin
        cmd.upd_y = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/ddodo_dp.sv
// ----------------------------------------------------------------------------
// ddodo_dp
// Odometry datapath: configuration registers, shared multiplier, iterative
// CORDIC, pose registers and the result register.
// ----------------------------------------------------------------------------
module ddodo_dp
  import ddodo_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  ddodo_in_t         in_data,
  input  dp_cmd_t           cmd,
  output ddodo_out_t        out_data
);

  logic [15:0]        wheel_radius_r;
  logic [23:0]        track_recip_r;
  logic [15:0]        time_step_r;
  logic signed [23:0] start_x_r;
  logic signed [23:0] start_y_r;
  logic signed [15:0] start_heading_r;

  logic signed [23:0] pos_x_r;
  logic signed [23:0] pos_y_r;
  logic signed [15:0] heading_r;

  logic signed [16:0] sum_r;
  logic signed [16:0] diff_r;
  logic signed [23:0] v8_r;
  logic signed [63:0] prod_r;

  logic signed [26:0] cx_r;
  logic signed [26:0] cy_r;
  logic signed [32:0] cz_r;
  logic               cneg_r;

  ddodo_out_t         out_data_r;

  logic signed [32:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [63:0] mul_p;
  logic signed [26:0] cos_v;
  logic signed [26:0] sin_v;
  logic signed [16:0] h_ext;
  logic signed [16:0] h_adj;
  logic               h_fold;
  logic signed [26:0] cx_sh;
  logic signed [26:0] cy_sh;
  logic signed [32:0] atan_v;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_radius_r  <= WHEEL_RADIUS_RST;
      track_recip_r   <= TRACK_RECIP_RST;
      time_step_r     <= TIME_STEP_RST;
      start_x_r       <= START_X_RST;
      start_y_r       <= START_Y_RST;
      start_heading_r <= START_HEADING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHEEL_RADIUS:     wheel_radius_r  <= cfg_data[15:0];
        CFG_TRACK_RECIPROCAL: track_recip_r   <= cfg_data;
        CFG_TIME_STEP:        time_step_r     <= cfg_data[15:0];
        CFG_START_X:          start_x_r       <= cfg_data;
        CFG_START_Y:          start_y_r       <= cfg_data;
        CFG_START_HEADING:    start_heading_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // corrected CORDIC outputs
  assign cos_v = cneg_r ? -cx_r : cx_r;
  assign sin_v = cneg_r ? -cy_r : cy_r;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.mul_tdt) begin
      // (v * trig) >> 24, times the time step
      mul_a = {{6{prod_r[50]}}, prod_r[50:24]};
      mul_b = $signed({15'b0, time_step_r});
    end else begin
      case (cmd.mul_sel)
        MS_SUM: begin
          mul_a = $signed({17'b0, wheel_radius_r});
          mul_b = {{14{sum_r[16]}}, sum_r};
        end
        MS_DIFF: begin
          mul_a = $signed({17'b0, wheel_radius_r});
          mul_b = {{14{diff_r[16]}}, diff_r};
        end
        MS_TRK: begin
          mul_a = prod_r[32:0];
          mul_b = $signed({7'b0, track_recip_r});
        end
        MS_DT_W: begin
          mul_a = prod_r[56:24];
          mul_b = $signed({15'b0, time_step_r});
        end
        MS_GAIN: begin
          mul_a = prod_r[48:16];
          mul_b = ANGLE_GAIN;
        end
        MS_VCOS: begin
          mul_a = {{9{v8_r[23]}}, v8_r};
          mul_b = {{4{cos_v[26]}}, cos_v};
        end
        MS_VSIN: begin
          mul_a = {{9{v8_r[23]}}, v8_r};
          mul_b = {{4{sin_v[26]}}, sin_v};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (cmd.load_in) begin
      sum_r  <= 17'(in_data.right_speed) + 17'(in_data.left_speed);
      diff_r <= 17'(in_data.right_speed) - 17'(in_data.left_speed);
    end
    if (cmd.cap_v8) begin
      v8_r <= prod_r[32:9];
    end
  end

  // fold the heading into +-pi/2 and negate the results afterwards
  assign h_ext  = 17'(heading_r);
  assign h_fold = (h_ext > 17'sd16384) || (h_ext < -17'sd16384);
  always_comb begin
    if (h_ext > 17'sd16384) begin
      h_adj = h_ext - 17'sd32768;
    end else if (h_ext < -17'sd16384) begin
      h_adj = h_ext + 17'sd32768;
    end else begin
      h_adj = h_ext;
    end
  end

  assign cx_sh  = cx_r >>> cmd.cor_idx;
  assign cy_sh  = cy_r >>> cmd.cor_idx;
  assign atan_v = $signed({1'b0, atan_lut(cmd.cor_idx)});

  always_ff @(posedge clk) begin
    if (cmd.cor_init) begin
      cx_r   <= CORDIC_K;
      cy_r   <= '0;
      cz_r   <= {h_adj, 16'b0};
      cneg_r <= h_fold;
    end else if (cmd.cor_step) begin
      if (!cz_r[32]) begin
        cx_r <= cx_r - cy_sh;
        cy_r <= cy_r + cx_sh;
        cz_r <= cz_r - atan_v;
      end else begin
        cx_r <= cx_r + cy_sh;
        cy_r <= cy_r - cx_sh;
        cz_r <= cz_r + atan_v;
      end
    end
  end

  // pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= START_X_RST;
      pos_y_r   <= START_Y_RST;
      heading_r <= START_HEADING_RST;
    end else begin
      if (cmd.load_in && in_data.restart) begin
        pos_x_r   <= start_x_r;
        pos_y_r   <= start_y_r;
        heading_r <= start_heading_r;
      end
      if (cmd.upd_head) begin
        heading_r <= heading_r + prod_r[47:32];
      end
      if (cmd.upd_x) begin
        pos_x_r <= pos_x_r + prod_r[39:16];
      end
      if (cmd.upd_y) begin
        pos_y_r <= pos_y_r + prod_r[39:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.pos_x   <= pos_x_r;
      out_data_r.pos_y   <= pos_y_r;
      out_data_r.heading <= heading_r;
    end
  end

  assign out_data = out_data_r;

endmodule

// File: src/differential_drive_odometry.sv
// A new input is taken only after the previous one has reached the result register (in_stall
//   is high outside the idle state); the shared multiplier schedule and one CORDIC rotation
//   per cycle set the pace, and a restart beat skips straight to the result load.
// A finished result waits in its own register while the next item is taken.
// Reset (rst_n, synchronous) loads configuration and pose defaults, clears valid.
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning pose integrator for a differential drive base.
// ----------------------------------------------------------------------------
module differential_drive_odometry
  import ddodo_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ddodo_in_t         in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ddodo_out_t        out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  ddodo_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_restart (in_data.restart),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd)
  );

  ddodo_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// File: dv/differential_drive_odometry_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_test
// Self-checking bench for the odometry integrator. It drives wheel-speed beats
// with random gaps and random output stalls, and reprograms the geometry and
// start pose between phases. It also holds the output off long enough to back
// up the input. Every pose beat is compared with a bit-exact fixed-point model
// of the integrator with its own CORDIC, or for pinned probes with a hand-read pose.
// ----------------------------------------------------------------------------
module differential_drive_odometry_test;
  import ddodo_pkg::*;

  localparam int ROT_STEPS       = 16;
  localparam int SETTLE          = ROT_STEPS + 14;
  localparam int JAM_CYCLES      = 300;
  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int N_PROBES        = 14;
  localparam int LIMIT_NS        = 2_000_000;

  localparam logic [CFG_IW-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IW-1:0] CFG_SPARE_B = 3'd7;

  // 2^32 / (2*pi) for a Q16 angle, CORDIC gain in Q24
  localparam longint TURN_SCALE   = 64'sd683565276;
  localparam longint ROT_GAIN     = 64'sd10188014;
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint HALF_TURN    = 64'sd2147483648;

  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
    logic               restart;
    logic               pinned;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [15:0] h;
  } probe_row_t;

  typedef struct {
    logic [15:0] radius;
    logic [23:0] track;
    logic [15:0] dt;
    logic [23:0] home_x;
    logic [23:0] home_y;
    logic [15:0] home_h;
  } odo_setting_t;

  // Directed beats at the reset geometry; pinned rows carry a pose read off by hand
  localparam probe_row_t PROBES [N_PROBES] = '{
    '{16'sd0, 16'sd0, 1'b1, 1'b1, -24'sd217600, -24'sd294400, 16'sd16384},
    '{16'sd0, 16'sd0, 1'b0, 1'b1, -24'sd217600, -24'sd294400, 16'sd16384},
    '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'sd0},
    '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'sd0},
    '{16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'sd0},
    '{16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'sd0},
    '{16'sh7FFF, 16'sh8000, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'sd0},
    '{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'sd0},
    '{16'sd1, 16'sd0, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'sd0},
    '{-16'sd1, 16'sd0, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'sd0},
    '{16'sd0, -16'sd1, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'sd0},
    '{16'sd256, 16'sd512, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'sd0},
    '{16'sh8000, 16'sh7FFF, 1'b1, 1'b1, -24'sd217600, -24'sd294400, 16'sd16384},
    '{16'sh7FFF, 16'sd0, 1'b0, 1'b0, 24'sd0, 24'sd0, 16'sd0}
  };

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  ddodo_in_t         in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  ddodo_out_t        out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = CFG_WHEEL_RADIUS;
  logic [CFG_DW-1:0] cfg_data  = '0;

  // Model copy of the configuration and the pose
  logic [15:0] radius_r = 16'd7680;
  logic [23:0] track_r  = 24'd74565;
  logic [15:0] dt_r     = 16'd2621;
  logic [23:0] home_x   = 24'hFCAE00;
  logic [23:0] home_y   = 24'hFB8200;
  logic [15:0] home_h   = 16'h4000;
  logic [23:0] pose_x   = 24'hFCAE00;
  logic [23:0] pose_y   = 24'hFB8200;
  logic [15:0] pose_h   = 16'h4000;

  longint atan_q32 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  ddodo_out_t pose_q [$];
  int         n_errors = 0;
  bit         calm     = 1'b0;
  bit         jam_req  = 1'b0;

  differential_drive_odometry #(
    .CORDIC_STEPS(ROT_STEPS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #LIMIT_NS;
    $display("differential_drive_odometry_test NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (n_errors < 100) $display("%0t: %s", $time, msg);
    n_errors++;
  endtask

  // Cosine and sine of a heading in Q24, by rotation in a 32-bit binary angle
  function automatic void heading_sincos(input logic [15:0] h, output longint c,
                                         output longint s);
    longint z, x, y, nx;
    bit     flip;
    int     n;
    z = $signed(h);
    z = z * 65536;
    x = ROT_GAIN;
    y = 0;
    flip = 1'b0;
    n = (ROT_STEPS > 24) ? 24 : ROT_STEPS;
    // fold the back half-plane onto the front and negate at the end
    if (z > QUARTER_TURN) begin
      z = z - HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z = z + HALF_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_q32[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_q32[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Advance the model pose by one wheel-speed beat and return the new pose
  function automatic ddodo_out_t integrate_pose(input ddodo_in_t b);
    longint r, l, rad, trk, dt, v8, w16, p16, dh, c, s, dx, dy;
    ddodo_out_t p;
    if (b.restart) begin
      pose_x = home_x;
      pose_y = home_y;
      pose_h = home_h;
    end else begin
      r   = b.right_speed;
      l   = b.left_speed;
      rad = radius_r;
      trk = track_r;
      dt  = dt_r;
      v8  = (rad * (r + l)) >>> 9;
      w16 = (rad * (r - l) * trk) >>> 24;
      p16 = (w16 * dt) >>> 16;
      dh  = (p16 * TURN_SCALE) >>> 32;
      pose_h = pose_h + dh[15:0];
      heading_sincos(pose_h, c, s);
      dx = (((v8 * c) >>> 24) * dt) >>> 16;
      dy = (((v8 * s) >>> 24) * dt) >>> 16;
      pose_x = pose_x + dx[23:0];
      pose_y = pose_y + dy[23:0];
    end
    p.pos_x   = pose_x;
    p.pos_y   = pose_y;
    p.heading = pose_h;
    return p;
  endfunction

  function automatic void apply_register(input logic [CFG_IW-1:0] idx,
                                         input logic [CFG_DW-1:0] val);
    case (idx)
      CFG_WHEEL_RADIUS:     radius_r = val[15:0];
      CFG_TRACK_RECIPROCAL: track_r  = val;
      CFG_TIME_STEP:        dt_r     = val[15:0];
      CFG_START_X:          home_x   = val;
      CFG_START_Y:          home_y   = val;
      CFG_START_HEADING:    home_h   = val[15:0];
      default: ;
    endcase
  endfunction

  task automatic put_register(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_register(idx, val);
  endtask

  // Upper data bits of the narrow registers carry junk that must be dropped
  task automatic program_setting(input odo_setting_t st, input bit spare);
    if (spare) put_register(CFG_SPARE_A, 24'($urandom));
    put_register(CFG_WHEEL_RADIUS, {8'($urandom), st.radius});
    put_register(CFG_TRACK_RECIPROCAL, st.track);
    put_register(CFG_TIME_STEP, {8'($urandom), st.dt});
    put_register(CFG_START_X, st.home_x);
    put_register(CFG_START_Y, st.home_y);
    put_register(CFG_START_HEADING, {8'($urandom), st.home_h});
    if (spare) put_register(CFG_SPARE_B, 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic odo_setting_t draw_setting();
    odo_setting_t st;
    st.radius = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(2000, 20000));
    st.track  = ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                            : 24'($urandom_range(20000, 400000));
    st.dt     = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(100, 8000));
    st.home_x = 24'($urandom);
    st.home_y = 24'($urandom);
    st.home_h = 16'($urandom);
    return st;
  endfunction

  function automatic ddodo_in_t draw_beat();
    ddodo_in_t b;
    b.restart = ($urandom_range(0, 19) == 0);
    case ($urandom_range(0, 3))
      0: begin
        b.right_speed = 16'($urandom);
        b.left_speed  = 16'($urandom);
      end
      1: begin
        b.right_speed = 16'($urandom_range(0, 1023) - 512);
        b.left_speed  = 16'($urandom_range(0, 1023) - 512);
      end
      2: begin
        b.right_speed = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        b.left_speed  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      default: begin
        // nearly straight run
        b.right_speed = 16'($urandom);
        b.left_speed  = b.right_speed + 16'($urandom_range(0, 63) - 32);
      end
    endcase
    return b;
  endfunction

  task automatic offer_beat(input ddodo_in_t b, input bit pinned, input ddodo_out_t pinned_pose);
    int         gap;
    ddodo_out_t predicted;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = integrate_pose(b);
    pose_q.push_back(pinned ? pinned_pose : predicted);
  endtask

  task automatic drain();
    while (pose_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : result_side
    int         hold;
    ddodo_out_t got;
    ddodo_out_t want;
    wait (rst_n === 1'b1);
    forever begin
      if (jam_req) begin
        out_stall <= 1'b1;
        repeat (JAM_CYCLES) @(posedge clk);
        jam_req = 1'b0;
      end
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = out_data;
      if (pose_q.size() == 0) begin
        report_mismatch($sformatf("pose beat with nothing expected: x %0d y %0d h %0d",
                                  got.pos_x, got.pos_y, got.heading));
      end else begin
        want = pose_q.pop_front();
        if (got.pos_x !== want.pos_x)
          report_mismatch($sformatf("pos_x got %0d want %0d", got.pos_x, want.pos_x));
        if (got.pos_y !== want.pos_y)
          report_mismatch($sformatf("pos_y got %0d want %0d", got.pos_y, want.pos_y));
        if (got.heading !== want.heading)
          report_mismatch($sformatf("heading got %0d want %0d", got.heading, want.heading));
      end
    end
  end

  initial begin : stimulus
    ddodo_in_t    b;
    ddodo_out_t   pinned_pose;
    odo_setting_t cur;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_PROBES; k++) begin
      b.right_speed = PROBES[k].right;
      b.left_speed  = PROBES[k].left;
      b.restart     = PROBES[k].restart;
      pinned_pose   = '{PROBES[k].x, PROBES[k].y, PROBES[k].h};
      offer_beat(b, PROBES[k].pinned, pinned_pose);
    end
    in_valid <= 1'b0;

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0: cur = '{16'd7680, 24'd74565, 16'd2621, 24'hFCAE00, 24'hFB8200, 16'h4000};
        1: cur = '{16'hFFFF, 24'hFFFFFF, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF};
        2: cur = '{16'h0000, 24'h000000, 16'h0000, 24'h800000, 24'h800000, 16'h8000};
        3: begin
          // integration interval of zero: pose must hold
          cur = draw_setting();
          cur.dt = 16'd0;
        end
        default: cur = draw_setting();
      endcase
      program_setting(cur, ph == 5);
      calm = (ph % 3 == 2);
      // back up the pipe: hold the output while beats keep coming
      if (ph == 4) jam_req = 1'b1;
      b = draw_beat();
      b.restart = 1'b1;
      offer_beat(b, 1'b0, '0);
      for (int k = 1; k < ITEMS_PER_PHASE; k++) offer_beat(draw_beat(), 1'b0, '0);
      in_valid <= 1'b0;
    end

    drain();
    if (n_errors == 0 && pose_q.size() == 0) begin
      $display("differential_drive_odometry_test OK");
    end else begin
      $display("differential_drive_odometry_test NOT OK");
    end
    $finish;
  end

endmodule
